FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/yawcam_pkg.sv
// Types, constants and helper functions for the yaw/pitch camera block.
package yawcam_pkg;

    localparam int IN_DATA_W  = 32;   // mouse_delta, move_amount
    localparam int IN_USER_W  = 2;    // opcode
    localparam int OUT_DATA_W = 144;  // pos_x/y/z, dir_x/y/z
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 49;

    typedef enum logic [1:0] {
        OP_YAW    = 2'd0,
        OP_PITCH  = 2'd1,
        OP_MOVE   = 2'd2,
        OP_STRAFE = 2'd3
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SCALE = 2'd2;

    localparam logic [11:0] ROT_STEP_RESET    = 12'd36;
    localparam logic [13:0] PITCH_LIM_RESET   = 14'd16202;
    localparam logic [15:0] MOVE_SCALE_RESET  = 16'd6554;
    localparam logic [15:0] YAW_RESET         = 16'd16384;
    localparam logic signed [31:0] POS_Y_RESET = 32'sd117965;
    localparam logic signed [31:0] POS_Z_RESET = -32'sd327680;
    localparam logic signed [15:0] DIR_Z_RESET = 16'sd32767;

    localparam int CORDIC_STEPS = 14;
    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
    localparam logic [15:0] QUARTER_TURN_NEG   = 16'hC000;  // -90 degrees

    // sine/cosine unit result
    typedef struct packed {
        logic               done;
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } t_cs_out;

    function automatic logic [13:0] atan_at(input logic [3:0] i);
        logic [13:0] v;
        unique case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [15:0] r;
        if (v > 49'sd32767)       r = 16'sd32767;
        else if (v < -49'sd32768) r = -16'sd32768;
        else                      r = v[15:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/yawcam_cordic.sv
// Iterative rotation CORDIC: sine and cosine of a 16-bit binary angle, one step per cycle.
module yawcam_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [15:0]          i_angle,
    output yawcam_pkg::t_cs_out  o_res
);
    import yawcam_pkg::*;

    logic signed [19:0] r_x, r_y;
    logic signed [17:0] r_z;
    logic [3:0]         r_cnt;
    logic               r_busy, r_done, r_flip;

    logic signed [15:0] ang_s, ang_f;
    logic               need_flip;
    logic signed [19:0] dx, dy, xf, yf;
    logic signed [17:0] at;
    logic signed [20:0] xh, yh;

    // fold into [-90, +90] degrees
    assign ang_s     = signed'(i_angle);
    assign need_flip = (ang_s > 16'sd16384) || (ang_s < -16'sd16384);
    assign ang_f     = need_flip ? signed'(i_angle + 16'h8000) : ang_s;

    assign dx = r_y >>> r_cnt;
    assign dy = r_x >>> r_cnt;
    assign at = signed'({4'd0, atan_at(r_cnt)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 4'(CORDIC_STEPS - 1));
            if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                if (r_cnt == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 4'd1;
            end else if (i_start) begin
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= 18'(ang_f);
                r_flip <= need_flip;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end
        end
    end

    assign xf = r_flip ? -r_x : r_x;
    assign yf = r_flip ? -r_y : r_y;
    assign xh = (21'(xf) + 21'sd1) >>> 1;
    assign yh = (21'(yf) + 21'sd1) >>> 1;

    assign o_res.done  = r_done;
    assign o_res.cos_v = sat16({{28{xh[20]}}, xh});
    assign o_res.sin_v = sat16({{28{yh[20]}}, yh});

endmodule

FILE: hw/rtl/yaw_pitch_camera_update_top.sv
// Top level of the first-person camera: state, sequencer and shared multiplier.
//
// Usage:
//   Input stream s_axis: tuser carries the opcode (rotate yaw, rotate pitch,
//   move, strafe), tdata carries mouse_delta and move_amount.
//   Output stream m_axis: one word per input word with position (Q15.16)
//   and view direction (Q1.15) after the update.
//   Config channel: index/data writes to rotation_step, pitch_limit and
//   move_scale; always ready, write only while the block is idle.
// Timing:
//   One word at a time; s_axis_tready is high only in the idle state.
//   Rotate: two 14-step passes of the CORDIC unit (yaw, then pitch)
//   plus the direction products. Move: two passes per
//   axis through the shared 32x17 multiplier; strafe: one CORDIC
//   pass plus two axes. The result becomes valid as the block returns to idle.
//   The result sits in an output register; a new word is accepted while it
//   waits, and the next result is held back until it has been taken.
// Reset:
//   Synchronous, active low; restores the power-up camera pose and the
//   default register values and drops m_axis_tvalid.
module yaw_pitch_camera_update_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // opcode
    input  logic [yawcam_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // mouse_delta [15:0], move_amount [31:16]
    input  logic [yawcam_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64],
    // dir_x [111:96], dir_y [127:112], dir_z [143:128]
    output logic [yawcam_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [yawcam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [yawcam_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import yawcam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TURN_MUL,
        S_TURN_APPLY,
        S_CS_YAW_GO,
        S_CS_YAW_WAIT,
        S_CS_PITCH_WAIT,
        S_DIR_X_MUL,
        S_DIR_Z_MUL,
        S_DIR_Z_WR,
        S_STRAFE_WAIT,
        S_ADV_MUL1,
        S_ADV_MUL2,
        S_ADV_ADD,
        S_OUT
    } t_state;

    t_state r_state;

    logic [11:0] r_rot_step;
    logic [13:0] r_pitch_lim;
    logic [15:0] r_move_scale;

    t_opcode            r_op;
    logic signed [15:0] r_delta, r_amount;
    logic [1:0]         r_axis;

    logic [15:0]        r_yaw;
    logic signed [15:0] r_pitch;
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_dir_x, r_dir_y, r_dir_z;
    logic signed [15:0] r_cy, r_sy, r_cp;

    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_valid;

    logic signed [PROD_W-1:0] r_prod, prod_c;
    logic signed [31:0]       mul_a;
    logic signed [16:0]       mul_b;

    logic               cs_start;
    logic [15:0]        cs_angle;
    t_cs_out            cs_res;

    logic               in_acc;
    logic signed [15:0] comp;
    logic signed [15:0] rnd15;
    logic signed [29:0] pitch_sum, lim_p;
    logic signed [21:0] step;
    logic signed [33:0] pos_sum;
    logic signed [31:0] pos_sat;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tvalid = r_out_valid;

    yawcam_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cs_start),
        .i_angle (cs_angle),
        .o_res   (cs_res)
    );

    always_comb begin
        cs_start = 1'b0;
        cs_angle = r_yaw;
        if (r_state == S_IDLE && in_acc && t_opcode'(s_axis_tuser) == OP_STRAFE) begin
            cs_start = 1'b1;
            cs_angle = r_yaw + QUARTER_TURN_NEG;
        end else if (r_state == S_CS_YAW_GO) begin
            cs_start = 1'b1;
        end else if (r_state == S_CS_YAW_WAIT && cs_res.done) begin
            cs_start = 1'b1;
            cs_angle = r_pitch;
        end
    end

    // component the current axis advances along
    always_comb begin
        unique case (r_axis)
            2'd0:    comp = (r_op == OP_MOVE) ? r_dir_x : r_cy;
            2'd2:    comp = (r_op == OP_MOVE) ? r_dir_z : r_sy;
            default: comp = r_dir_y;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = 32'(r_delta);
        mul_b = signed'({5'd0, r_rot_step});
        unique case (r_state)
            S_DIR_X_MUL: begin
                mul_a = 32'(r_cy);
                mul_b = 17'(r_cp);
            end
            S_DIR_Z_MUL: begin
                mul_a = 32'(r_sy);
                mul_b = 17'(r_cp);
            end
            S_ADV_MUL1: begin
                mul_a = 32'(r_amount);
                mul_b = 17'(comp);
            end
            S_ADV_MUL2: begin
                mul_a = r_prod[31:0];
                mul_b = signed'({1'b0, r_move_scale});
            end
            default: ;
        endcase
    end

    assign prod_c = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
    end

    assign rnd15     = sat16((r_prod + 49'sd16384) >>> 15);
    assign pitch_sum = 30'(r_pitch) + 30'(signed'(r_prod[27:0]));
    assign lim_p     = signed'({16'd0, r_pitch_lim});
    assign step      = 22'((r_prod + 49'sd67108864) >>> 27);
    assign pos_sum   = 34'(r_pos[r_axis]) + 34'(step);

    always_comb begin
        if (pos_sum > 34'sd2147483647)       pos_sat = 32'sh7FFFFFFF;
        else if (pos_sum < -34'sd2147483648) pos_sat = 32'sh80000000;
        else                                 pos_sat = pos_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rot_step   <= ROT_STEP_RESET;
            r_pitch_lim  <= PITCH_LIM_RESET;
            r_move_scale <= MOVE_SCALE_RESET;
            r_yaw        <= YAW_RESET;
            r_pitch      <= '0;
            r_pos[0]     <= '0;
            r_pos[1]     <= POS_Y_RESET;
            r_pos[2]     <= POS_Z_RESET;
            r_dir_x      <= '0;
            r_dir_y      <= '0;
            r_dir_z      <= DIR_Z_RESET;
            r_out_valid  <= 1'b0;
            r_axis       <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROT_STEP:   r_rot_step   <= i_cfg_data[11:0];
                    CFG_PITCH_LIM:  r_pitch_lim  <= i_cfg_data[13:0];
                    CFG_MOVE_SCALE: r_move_scale <= i_cfg_data;
                    default: ;
                endcase
            end

            // S_OUT reloads the output register itself
            if (r_out_valid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= t_opcode'(s_axis_tuser);
                        r_delta  <= signed'(s_axis_tdata[15:0]);
                        r_amount <= signed'(s_axis_tdata[31:16]);
                        r_axis   <= '0;
                        unique case (t_opcode'(s_axis_tuser))
                            OP_YAW, OP_PITCH: r_state <= S_TURN_MUL;
                            OP_MOVE:          r_state <= S_ADV_MUL1;
                            OP_STRAFE:        r_state <= S_STRAFE_WAIT;
                        endcase
                    end
                end
                S_TURN_MUL: r_state <= S_TURN_APPLY;
                S_TURN_APPLY: begin
                    if (r_op == OP_YAW) begin
                        r_yaw <= r_yaw + r_prod[15:0];
                    end else if (pitch_sum > lim_p) begin
                        r_pitch <= lim_p[15:0];
                    end else if (pitch_sum < -lim_p) begin
                        r_pitch <= 16'(-lim_p);
                    end else begin
                        r_pitch <= pitch_sum[15:0];
                    end
                    r_state <= S_CS_YAW_GO;
                end
                S_CS_YAW_GO: r_state <= S_CS_YAW_WAIT;
                S_CS_YAW_WAIT: begin
                    if (cs_res.done) begin
                        r_cy    <= cs_res.cos_v;
                        r_sy    <= cs_res.sin_v;
                        r_state <= S_CS_PITCH_WAIT;
                    end
                end
                S_CS_PITCH_WAIT: begin
                    if (cs_res.done) begin
                        r_cp    <= cs_res.cos_v;
                        r_dir_y <= cs_res.sin_v;
                        r_state <= S_DIR_X_MUL;
                    end
                end
                S_DIR_X_MUL: r_state <= S_DIR_Z_MUL;
                S_DIR_Z_MUL: begin
                    r_dir_x <= rnd15;
                    r_state <= S_DIR_Z_WR;
                end
                S_DIR_Z_WR: begin
                    r_dir_z <= rnd15;
                    r_state <= S_OUT;
                end
                S_STRAFE_WAIT: begin
                    if (cs_res.done) begin
                        r_cy    <= cs_res.cos_v;
                        r_sy    <= cs_res.sin_v;
                        r_state <= S_ADV_MUL1;
                    end
                end
                S_ADV_MUL1: r_state <= S_ADV_MUL2;
                S_ADV_MUL2: r_state <= S_ADV_ADD;
                S_ADV_ADD: begin
                    r_pos[r_axis] <= pos_sat;
                    if (r_axis == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        // strafe skips the vertical axis
                        r_axis  <= (r_op == OP_MOVE) ? r_axis + 2'd1 : 2'd2;
                        r_state <= S_ADV_MUL1;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= {r_dir_z, r_dir_y, r_dir_x,
                                        r_pos[2], r_pos[1], r_pos[0]};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/yawcam_checker.sv
// Port-level checker for the camera block, bound to the top level.
`include "assert_macros.svh"

module yawcam_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [yawcam_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic                                o_cfg_ready
);
    import yawcam_pkg::*;

    // stalled word holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // no word left over from before reset
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // one word at a time: busy right after an accept
    `ASSERT_CLK(a_busy_after_acc, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // a result is never shown right after its accept
    `ASSERT_CLK(a_no_instant_out, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))

    `ASSERT_CLK(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready)

endmodule

bind yaw_pitch_camera_update_top yawcam_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .o_cfg_ready   (o_cfg_ready)
);

FILE: tb/tb.sv
// Self-checking testbench for the yaw/pitch camera block: stream in, predicted pose out.
`timescale 1ns / 100ps

module tb;
    import yawcam_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int END_CYCLES     = 50;
    localparam int MAX_REPORTS    = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } cam_pose_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic [IN_USER_W-1:0]    s_axis_tuser = '0;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    yaw_pitch_camera_update_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // camera model state and register copies
    logic [15:0] cam_yaw;
    int          cam_pitch;
    int          cam_px, cam_py, cam_pz;
    int          cam_dx, cam_dy, cam_dz;
    int          rot_step_q, pitch_lim_q, move_scale_q;

    int arctan_lut [0:13] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

    cam_pose_t expected_poses[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_requests = 0;

    function automatic int clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int clip32(input longint v);
        if (v > POS_MAX) return int'(POS_MAX);
        if (v < POS_MIN) return int'(POS_MIN);
        return int'(v);
    endfunction

    // rotation CORDIC; angles past +-90 deg are turned half a turn and negated after
    function automatic void sin_cos_q15(input logic [15:0] ang, output int c, output int s);
        logic [15:0] folded;
        bit          flip;
        longint      x, y, z, dx, dy;
        folded = ang;
        flip = 1'b0;
        if ($signed(ang) > 16'sd16384 || $signed(ang) < -16'sd16384) begin
            folded = ang + 16'h8000;
            flip = 1'b1;
        end
        x = CORDIC_GAIN;
        y = 0;
        z = longint'($signed(folded));
        for (int i = 0; i < 14; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_lut[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_lut[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip16((x + 1) >>> 1);
        s = clip16((y + 1) >>> 1);
    endfunction

    function automatic int mul_q15(input int a, input int b);
        return clip16((longint'(a) * b + 16384) >>> 15);
    endfunction

    function automatic void refresh_direction();
        int cy, sy, cp, sp;
        sin_cos_q15(cam_yaw, cy, sy);
        sin_cos_q15(cam_pitch[15:0], cp, sp);
        cam_dx = mul_q15(cy, cp);
        cam_dy = sp;
        cam_dz = mul_q15(sy, cp);
    endfunction

    function automatic int step_axis(input int pos, input int amount, input int comp);
        longint p;
        p = longint'(amount) * comp * longint'(move_scale_q);
        return clip32(longint'(pos) + ((p + (64'sd1 <<< 26)) >>> 27));
    endfunction

    function automatic cam_pose_t predict_pose(input t_opcode op, input int delta,
                                               input int amount);
        longint      turn, p;
        int          c, s;
        logic [15:0] side;
        cam_pose_t   r;
        turn = longint'(rot_step_q) * delta;
        case (op)
            OP_YAW: begin
                cam_yaw = cam_yaw + turn[15:0];
                refresh_direction();
            end
            OP_PITCH: begin
                p = longint'(cam_pitch) + turn;
                if (p > pitch_lim_q) p = pitch_lim_q;
                if (p < -pitch_lim_q) p = -pitch_lim_q;
                cam_pitch = int'(p);
                refresh_direction();
            end
            OP_MOVE: begin
                cam_px = step_axis(cam_px, amount, cam_dx);
                cam_py = step_axis(cam_py, amount, cam_dy);
                cam_pz = step_axis(cam_pz, amount, cam_dz);
            end
            default: begin
                side = cam_yaw + QUARTER_TURN_NEG;
                sin_cos_q15(side, c, s);
                cam_px = step_axis(cam_px, amount, c);
                cam_pz = step_axis(cam_pz, amount, s);
            end
        endcase
        r.pos_x = cam_px;
        r.pos_y = cam_py;
        r.pos_z = cam_pz;
        r.dir_x = cam_dx[15:0];
        r.dir_y = cam_dy[15:0];
        r.dir_z = cam_dz[15:0];
        return r;
    endfunction

    // ---------------- result checking ----------------
    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        cam_pose_t want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pos_x = m_axis_tdata[31:0];
            got.pos_y = m_axis_tdata[63:32];
            got.pos_z = m_axis_tdata[95:64];
            got.dir_x = m_axis_tdata[111:96];
            got.dir_y = m_axis_tdata[127:112];
            got.dir_z = m_axis_tdata[143:128];
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word with nothing pending: pos_x %0d", got.pos_x);
            end else begin
                want = expected_poses.pop_front();
                check_field("pos_x", want.pos_x, got.pos_x);
                check_field("pos_y", want.pos_y, got.pos_y);
                check_field("pos_z", want.pos_z, got.pos_z);
                check_field("dir_x", want.dir_x, got.dir_x);
                check_field("dir_y", want.dir_y, got.dir_y);
                check_field("dir_z", want.dir_z, got.dir_z);
            end
        end
    end

    // receiver: random stalls, plus a long hold whenever a test asks for one
    int hold_taken = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_requests != hold_taken) begin
            hold_taken = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------- drivers ----------------
    task automatic send_word(input t_opcode op, input logic [15:0] delta,
                             input logic [15:0] amount);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {amount, delta};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        expected_poses.push_back(predict_pose(op, $signed(delta), $signed(amount)));
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_ROT_STEP:   rot_step_q   = int'(value[11:0]);
            CFG_PITCH_LIM:  pitch_lim_q  = int'(value[13:0]);
            CFG_MOVE_SCALE: move_scale_q = int'(value);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_delta();
        if ($urandom_range(1) == 0) return 16'($urandom_range(64)) - 16'd32;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_amount();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            1:       return 16'($urandom_range(8192)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_reg_value(input logic [15:0] top);
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return top;
            2:       return 16'($urandom) & top;
            default: return 16'($urandom);  // bits above the field get masked
        endcase
    endfunction

    task automatic shuffle_registers();
        write_register(CFG_ROT_STEP, pick_reg_value(16'h0FFF));
        write_register(CFG_PITCH_LIM, pick_reg_value(16'h3FFF));
        write_register(CFG_MOVE_SCALE, pick_reg_value(16'hFFFF));
        if ($urandom_range(3) == 0)
            write_register(CFG_UNUSED_IDX, 16'($urandom));
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ---------------- tests ----------------
    task automatic test_each_operation();
        send_word(OP_MOVE,   16'hFFFF, 16'h7FFF);
        send_word(OP_STRAFE, 16'h0000, 16'h7FFF);
        send_word(OP_STRAFE, 16'h7FFF, 16'h8000);
        send_word(OP_MOVE,   16'h0000, 16'h8000);
        send_word(OP_YAW,    16'h7FFF, 16'h8000);  // wraps the yaw
        send_word(OP_YAW,    16'h8000, 16'h0000);
        send_word(OP_YAW,    16'h0000, 16'h7FFF);
        send_word(OP_PITCH,  16'h7FFF, 16'hFFFF);  // clamps high
        send_word(OP_PITCH,  16'h8000, 16'h0000);  // clamps low
        send_word(OP_PITCH,  16'h0001, 16'h0000);
        send_word(OP_YAW,    16'h0001, 16'h0000);
        send_word(OP_YAW,    16'hFFFF, 16'h0000);
        send_word(OP_MOVE,   16'h0000, 16'h0000);
    endtask

    task automatic test_register_writes();
        wait_until_drained();
        write_register(CFG_UNUSED_IDX, 16'hFFFF);
        send_word(OP_YAW, 16'd100, 16'h0000);
        wait_until_drained();
        write_register(CFG_ROT_STEP, 16'h0000);
        send_word(OP_YAW, 16'h8000, 16'h0000);
        wait_until_drained();
        write_register(CFG_ROT_STEP, 16'hFFFF);
        write_register(CFG_PITCH_LIM, 16'hFFFF);
        send_word(OP_YAW, 16'h7FFF, 16'h0000);
        send_word(OP_PITCH, 16'h7FFF, 16'h0000);
        wait_until_drained();
        write_register(CFG_PITCH_LIM, 16'h0000);
        write_register(CFG_MOVE_SCALE, 16'h0000);
        send_word(OP_PITCH, 16'd5, 16'h0000);
        send_word(OP_MOVE, 16'h0000, 16'h7FFF);
        wait_until_drained();
        write_register(CFG_MOVE_SCALE, 16'hFFFF);
        send_word(OP_MOVE, 16'h0000, 16'h7FFF);
        send_word(OP_STRAFE, 16'h0000, 16'h8000);
        wait_until_drained();
        write_register(CFG_ROT_STEP, 16'(ROT_STEP_RESET));
        write_register(CFG_PITCH_LIM, 16'(PITCH_LIM_RESET));
        write_register(CFG_MOVE_SCALE, MOVE_SCALE_RESET);
    endtask

    task automatic test_random_traffic(input int n_words);
        for (int k = 0; k < n_words; k++) begin
            if (k % 200 == 0) begin
                wait_until_drained();
                shuffle_registers();
            end
            send_word(t_opcode'($urandom_range(3)), rand_delta(), rand_amount());
        end
    endtask

    // receiver holds off while words keep coming, then the sender waits it out
    task automatic test_backpressure();
        hold_requests++;
        for (int k = 0; k < 10; k++)
            send_word(t_opcode'($urandom_range(3)), rand_delta(), rand_amount());
        wait_until_drained();
        for (int k = 0; k < 6; k++)
            send_word(t_opcode'($urandom_range(3)), rand_delta(), rand_amount());
    endtask

    // full speed straight runs: diagonally in x and z, then straight up
    task automatic test_full_speed_runs();
        logic [15:0] yaw_fix, pitch_fix;
        wait_until_drained();
        write_register(CFG_ROT_STEP, 16'd1);
        write_register(CFG_PITCH_LIM, 16'h3FFF);
        write_register(CFG_MOVE_SCALE, 16'hFFFF);
        yaw_fix = 16'hE000 - cam_yaw;          // -45 degrees: +x and -z
        pitch_fix = 16'(-cam_pitch);
        send_word(OP_YAW, yaw_fix, 16'h0000);
        send_word(OP_PITCH, pitch_fix, 16'h0000);
        repeat (300) send_word(OP_MOVE, 16'h0000, 16'h7FFF);
        repeat (4) send_word(OP_MOVE, 16'h0000, 16'h8000);
        send_word(OP_PITCH, 16'h7FFF, 16'h0000);
        repeat (300) send_word(OP_MOVE, 16'h0000, 16'h7FFF);
        repeat (4) send_word(OP_MOVE, 16'h0000, 16'h8000);
    endtask

    initial begin
        rot_step_q   = int'(ROT_STEP_RESET);
        pitch_lim_q  = int'(PITCH_LIM_RESET);
        move_scale_q = int'(MOVE_SCALE_RESET);
        cam_yaw   = YAW_RESET;
        cam_pitch = 0;
        cam_px    = 0;
        cam_py    = POS_Y_RESET;
        cam_pz    = POS_Z_RESET;
        cam_dx    = 0;
        cam_dy    = 0;
        cam_dz    = DIR_Z_RESET;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(6, 66);
        test_each_operation();
        test_register_writes();
        test_random_traffic(400);
        set_idling(66, 6);
        test_random_traffic(400);
        set_idling(0, 0);
        test_backpressure();
        test_random_traffic(400);
        test_full_speed_runs();

        wait_until_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_poses.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
